// File: rtl/core/bas_pkg.sv
`timescale 1ns / 1ps
package bas_pkg;

  // Store and coordinate defaults
  localparam int unsigned SRC_PIXELS_DEF     = 65536;
  localparam int unsigned DST_COORD_BITS_DEF = 12;
  localparam int unsigned STEP_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned LOAD_ADR_W = 16;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_X_RST     = 24'd65536;
  localparam logic [STEP_W-1:0] STEP_Y_RST     = 24'd65536;

  // Lerp constants
  localparam logic [PIX_W-1:0] PAIR_MASK    = 32'h00FF00FF;
  localparam int unsigned      WEIGHT_SHIFT = 8;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_STEP_X     = 2'd2,
    CFG_STEP_Y     = 2'd3
  } cfg_idx_t;

endpackage

// File: rtl/core/bas_in_if.sv
`timescale 1ns / 1ps
interface bas_in_if #(
  parameter int unsigned COORD_W = bas_pkg::DST_COORD_BITS_DEF
);
  import bas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [LOAD_ADR_W-1:0] load_addr;
  logic [PIX_W-1:0]      load_pixel;
  logic [COORD_W-1:0]    dst_x;
  logic [COORD_W-1:0]    dst_y;

  modport source (output valid, cmd, load_addr, load_pixel, dst_x, dst_y, input ready);
  modport sink   (input valid, cmd, load_addr, load_pixel, dst_x, dst_y, output ready);

endinterface

// File: rtl/core/bas_out_if.sv
`timescale 1ns / 1ps
interface bas_out_if;
  import bas_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);

endinterface

// File: rtl/core/bas_ram.sv
`timescale 1ns / 1ps
module bas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bilinear_argb_image_scaler.sv
`timescale 1ns / 1ps
// Bilinear ARGB8888 scaler with an on-chip source image store.
// in_if (valid/ready): cmd 0 loads load_pixel at load_addr into the store and
// gives no result; cmd 1 samples the source at destination (dst_x, dst_y) and
// gives one pixel on out_if (valid/ready). Results leave in input order.
// cfg_we/cfg_addr/cfg_wdata write src_width, src_height, step_x, step_y
// (indexes 0..3); write them only while no item is in flight.
// Seven register stages: input, position multiply, clamp and weights, address
// multiply, store read, horizontal lerps, vertical lerp into the output
// register. While out_if.ready stays high, one item per cycle is accepted and
// delivered; the rate is set by the four replicated store copies, one read
// port per neighbor, all written together from the store-access stage so
// loads and reads stay in order.
// The store holds SRC_PIXELS words (power of two); addresses wrap at its size.
// Reset clears every stage valid bit and restores the registers; the store is
// not cleared, and a read of a never-written entry returns undefined data.
// When out_if.ready is low, stages fill up behind the output register and
// in_if.ready drops only once every stage holds an item; nothing is lost.
module bilinear_argb_image_scaler #(
  parameter int unsigned SRC_PIXELS     = bas_pkg::SRC_PIXELS_DEF,
  parameter int unsigned DST_COORD_BITS = bas_pkg::DST_COORD_BITS_DEF,
  parameter int unsigned STEP_FRAC_BITS = bas_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bas_in_if.sink                        in_if,
  bas_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [bas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bas_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bas_pkg::*;

  localparam int unsigned ADDR_W = $clog2(SRC_PIXELS);
  localparam int unsigned POS_W  = DST_COORD_BITS + STEP_W;
  localparam int unsigned IP_W   = POS_W - STEP_FRAC_BITS;
  localparam int unsigned CMP_W  = (IP_W > SIZE_W) ? IP_W : SIZE_W;
  localparam int unsigned PROD_W = 2 * SIZE_W;
  localparam int unsigned SUM_A  = (PROD_W > LOAD_ADR_W) ? PROD_W : LOAD_ADR_W;
  localparam int unsigned SUM_W  = (SUM_A > ADDR_W) ? SUM_A : ADDR_W;
  localparam int unsigned WP_W   = STEP_FRAC_BITS + WEIGHT_W;

  // ---------------------------------------------------------------- lerp
  function automatic logic [PIX_W-1:0] mix_pair(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [WEIGHT_W-1:0] w);
    logic [PIX_W-1:0] acc;
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] prod;
    acc  = a & PAIR_MASK;
    diff = (b & PAIR_MASK) - acc;
    prod = diff * PIX_W'(w);
    acc  = acc + (prod >> WEIGHT_SHIFT);
    return acc & PAIR_MASK;
  endfunction

  function automatic logic [PIX_W-1:0] mix_argb(input logic [PIX_W-1:0] p0,
                                                 input logic [PIX_W-1:0] p1,
                                                 input logic [WEIGHT_W-1:0] w);
    logic [PIX_W-1:0] rb;
    logic [PIX_W-1:0] ag;
    rb = mix_pair(p0, p1, w);
    ag = mix_pair(p0 >> 8, p1 >> 8, w);
    return rb | (ag << 8);
  endfunction

  // ---------------------------------------------------------------- config
  logic [SIZE_W-1:0] src_width_r;
  logic [SIZE_W-1:0] src_height_r;
  logic [STEP_W-1:0] step_x_r;
  logic [STEP_W-1:0] step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      step_x_r     <= STEP_X_RST;
      step_y_r     <= STEP_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_STEP_X:     step_x_r     <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_Y:     step_y_r     <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] cols;
  logic [SIZE_W-1:0] last_x;
  logic [SIZE_W-1:0] last_y;

  // zero size counts as one
  assign cols   = (src_width_r == '0) ? SIZE_W'(1) : src_width_r;
  assign last_x = cols - SIZE_W'(1);
  assign last_y = (src_height_r == '0) ? '0 : src_height_r - SIZE_W'(1);

  // ---------------------------------------------------------------- flow
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !s7_v_r || out_if.ready;
  assign rdy6 = !s6_v_r || rdy7;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_if.ready = rdy1;

  logic s4_cmd_r;
  logic s4_sample;
  assign s4_sample = (s4_cmd_r == CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_if.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      // loads end in the store-access stage
      if (rdy5) s5_v_r <= s4_v_r && s4_sample;
      if (rdy6) s6_v_r <= s5_v_r;
      if (rdy7) s7_v_r <= s6_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                      s1_cmd_r;
  logic [LOAD_ADR_W-1:0]     s1_laddr_r;
  logic [PIX_W-1:0]          s1_lpix_r;
  logic [DST_COORD_BITS-1:0] s1_dx_r;
  logic [DST_COORD_BITS-1:0] s1_dy_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cmd_r   <= in_if.cmd;
      s1_laddr_r <= in_if.load_addr;
      s1_lpix_r  <= in_if.load_pixel;
      s1_dx_r    <= in_if.dst_x;
      s1_dy_r    <= in_if.dst_y;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [POS_W-1:0]      pos_x_nxt, pos_y_nxt;
  logic [POS_W-1:0]      s2_pos_x_r, s2_pos_y_r;
  logic                  s2_cmd_r;
  logic [LOAD_ADR_W-1:0] s2_laddr_r;
  logic [PIX_W-1:0]      s2_lpix_r;

  assign pos_x_nxt = POS_W'(s1_dx_r) * POS_W'(step_x_r);
  assign pos_y_nxt = POS_W'(s1_dy_r) * POS_W'(step_y_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_pos_x_r <= pos_x_nxt;
      s2_pos_y_r <= pos_y_nxt;
      s2_cmd_r   <= s1_cmd_r;
      s2_laddr_r <= s1_laddr_r;
      s2_lpix_r  <= s1_lpix_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [CMP_W-1:0]    ip_x, ip_y;
  logic [WP_W-1:0]     wp_x, wp_y;
  logic                clamp_x, clamp_y;
  logic [SIZE_W-1:0]   x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic [WEIGHT_W-1:0] wu_nxt, wv_nxt;

  assign ip_x = CMP_W'(s2_pos_x_r[POS_W-1:STEP_FRAC_BITS]);
  assign ip_y = CMP_W'(s2_pos_y_r[POS_W-1:STEP_FRAC_BITS]);
  // frac * 255 as (frac << 8) - frac
  assign wp_x = {s2_pos_x_r[STEP_FRAC_BITS-1:0], {WEIGHT_W{1'b0}}}
              - WP_W'(s2_pos_x_r[STEP_FRAC_BITS-1:0]);
  assign wp_y = {s2_pos_y_r[STEP_FRAC_BITS-1:0], {WEIGHT_W{1'b0}}}
              - WP_W'(s2_pos_y_r[STEP_FRAC_BITS-1:0]);

  assign clamp_x = (ip_x >= CMP_W'(last_x));
  assign clamp_y = (ip_y >= CMP_W'(last_y));

  assign x0_nxt = clamp_x ? last_x : SIZE_W'(ip_x);
  assign x1_nxt = clamp_x ? last_x : SIZE_W'(ip_x) + SIZE_W'(1);
  assign wu_nxt = clamp_x ? '0 : wp_x[WP_W-1:STEP_FRAC_BITS];
  assign y0_nxt = clamp_y ? last_y : SIZE_W'(ip_y);
  assign y1_nxt = clamp_y ? last_y : SIZE_W'(ip_y) + SIZE_W'(1);
  assign wv_nxt = clamp_y ? '0 : wp_y[WP_W-1:STEP_FRAC_BITS];

  logic [SIZE_W-1:0]     s3_x0_r, s3_x1_r, s3_y0_r, s3_y1_r;
  logic [WEIGHT_W-1:0]   s3_wu_r, s3_wv_r;
  logic                  s3_cmd_r;
  logic [LOAD_ADR_W-1:0] s3_laddr_r;
  logic [PIX_W-1:0]      s3_lpix_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_x0_r    <= x0_nxt;
      s3_x1_r    <= x1_nxt;
      s3_y0_r    <= y0_nxt;
      s3_y1_r    <= y1_nxt;
      s3_wu_r    <= wu_nxt;
      s3_wv_r    <= wv_nxt;
      s3_cmd_r   <= s2_cmd_r;
      s3_laddr_r <= s2_laddr_r;
      s3_lpix_r  <= s2_lpix_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [SUM_W-1:0]  row0, row1;
  logic [SUM_W-1:0]  sum00, sum01, sum10, sum11, sum_ld;
  logic [ADDR_W-1:0] addr_nxt [4];

  assign row0   = SUM_W'(s3_y0_r) * SUM_W'(cols);
  assign row1   = SUM_W'(s3_y1_r) * SUM_W'(cols);
  assign sum00  = row0 + SUM_W'(s3_x0_r);
  assign sum01  = row0 + SUM_W'(s3_x1_r);
  assign sum10  = row1 + SUM_W'(s3_x0_r);
  assign sum11  = row1 + SUM_W'(s3_x1_r);
  assign sum_ld = SUM_W'(s3_laddr_r);

  // port 0 doubles as the write address for a load
  assign addr_nxt[0] = (s3_cmd_r == CMD_LOAD) ? sum_ld[ADDR_W-1:0] : sum00[ADDR_W-1:0];
  assign addr_nxt[1] = sum01[ADDR_W-1:0];
  assign addr_nxt[2] = sum10[ADDR_W-1:0];
  assign addr_nxt[3] = sum11[ADDR_W-1:0];

  logic [ADDR_W-1:0]   s4_addr_r [4];
  logic [WEIGHT_W-1:0] s4_wu_r, s4_wv_r;
  logic [PIX_W-1:0]    s4_lpix_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 4; i++) begin
        s4_addr_r[i] <= addr_nxt[i];
      end
      s4_wu_r   <= s3_wu_r;
      s4_wv_r   <= s3_wv_r;
      s4_cmd_r  <= s3_cmd_r;
      s4_lpix_r <= s3_lpix_r;
    end
  end

  // ---------------------------------------------------------------- store
  logic             ram_we;
  logic [PIX_W-1:0] q [4];

  // all copies written together, in item order with the reads
  assign ram_we = s4_v_r && !s4_sample && rdy5;

  for (genvar g = 0; g < 4; g++) begin : g_copy
    bas_ram #(
      .WIDTH (PIX_W),
      .DEPTH (SRC_PIXELS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (s4_addr_r[0]),
      .wdata (s4_lpix_r),
      .re    (rdy5),
      .raddr (s4_addr_r[g]),
      .rdata (q[g])
    );
  end

  // ---------------------------------------------------------------- stage 5
  logic [WEIGHT_W-1:0] s5_wu_r, s5_wv_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_wu_r <= s4_wu_r;
      s5_wv_r <= s4_wv_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [PIX_W-1:0]    top_nxt, bot_nxt;
  logic [PIX_W-1:0]    s6_top_r, s6_bot_r;
  logic [WEIGHT_W-1:0] s6_wv_r;

  assign top_nxt = mix_argb(q[0], q[1], s5_wu_r);
  assign bot_nxt = mix_argb(q[2], q[3], s5_wu_r);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_top_r <= top_nxt;
      s6_bot_r <= bot_nxt;
      s6_wv_r  <= s5_wv_r;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic [PIX_W-1:0] pix_nxt;
  logic [PIX_W-1:0] s7_pix_r;

  assign pix_nxt = mix_argb(s6_top_r, s6_bot_r, s6_wv_r);

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_pix_r <= pix_nxt;
    end
  end

  assign out_if.valid = s7_v_r;
  assign out_if.pixel = s7_pix_r;

  // ---------------------------------------------------------------- checks
  a_sample_reaches_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_sample && rdy5) |=> s5_v_r)
    else $error("sample lost at store read");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !s4_sample && rdy5) |=> !s5_v_r)
    else $error("load produced a result");

  a_clamp_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && (s3_x0_r == s3_x1_r)) |-> (s3_wu_r == '0))
    else $error("nonzero weight at clamped column");

  a_neighbor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ((s3_x1_r <= last_x) && (s3_y1_r <= last_y)))
    else $error("neighbor index beyond image edge");

endmodule

// File: bench/bilinear_argb_image_scaler_test.sv
`timescale 1ns / 1ps
module bilinear_argb_image_scaler_test;
  import bas_pkg::*;

  localparam int unsigned COORD_W     = DST_COORD_BITS_DEF;
  localparam int unsigned FRAC_W      = STEP_FRAC_BITS_DEF;
  localparam int unsigned STORE_WORDS = SRC_PIXELS_DEF;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DOG_LIMIT   = 2000;

  typedef struct packed {
    cmd_t                  cmd;
    logic [LOAD_ADR_W-1:0] addr;
    logic [PIX_W-1:0]      pix;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
  } scaler_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  scaler_item_t tx_item  = '0;
  logic         tx_valid = 1'b0;
  logic         rx_ready = 1'b0;

  bas_in_if  in_if ();
  bas_out_if out_if ();

  assign in_if.valid      = tx_valid;
  assign in_if.cmd        = tx_item.cmd;
  assign in_if.load_addr  = tx_item.addr;
  assign in_if.load_pixel = tx_item.pix;
  assign in_if.dst_x      = tx_item.x;
  assign in_if.dst_y      = tx_item.y;
  assign out_if.ready     = rx_ready;

  bilinear_argb_image_scaler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Register copy, updated as the registers are written
  logic [SIZE_W-1:0] reg_width  = SRC_WIDTH_RST;
  logic [SIZE_W-1:0] reg_height = SRC_HEIGHT_RST;
  logic [STEP_W-1:0] reg_step_x = STEP_X_RST;
  logic [STEP_W-1:0] reg_step_y = STEP_Y_RST;

  logic [PIX_W-1:0] src_image_copy [0:STORE_WORDS-1];
  bit               loaded_map     [0:STORE_WORDS-1];

  scaler_item_t     feed_q[$];
  logic [PIX_W-1:0] pixel_q[$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned item_cnt     = 0;
  int unsigned fail_cnt     = 0;
  int unsigned dog_cnt      = 0;
  int unsigned rx_hold_cnt  = 0;
  bit          rx_hold_go   = 1'b0;
  bit          rx_hold_seen = 1'b0;
  bit          in_fire      = 1'b0;
  bit          out_fire     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void resolve_axis(
    input  logic [COORD_W-1:0]  coord,
    input  logic [STEP_W-1:0]   step,
    input  logic [SIZE_W-1:0]   size,
    output logic [SIZE_W-1:0]   base,
    output logic [SIZE_W-1:0]   nbr,
    output logic [WEIGHT_W-1:0] w
  );
    logic [COORD_W+STEP_W-1:0]  pos;
    logic [FRAC_W-1:0]          frac;
    logic [FRAC_W+WEIGHT_W-1:0] scaled;
    logic [SIZE_W-1:0]          last;
    pos    = coord * step;
    frac   = pos[FRAC_W-1:0];
    scaled = frac * 8'd255;
    last   = (size == '0) ? '0 : size - 1'b1;
    if ((pos >> FRAC_W) >= last) begin
      base = last;
      nbr  = last;
      w    = '0;
    end else begin
      base = pos[FRAC_W +: SIZE_W];
      nbr  = base + 1'b1;
      w    = scaled[FRAC_W +: WEIGHT_W];
    end
  endfunction

  // Row-major address; truncation gives the wrap at the store size
  function automatic logic [LOAD_ADR_W-1:0] pixel_addr(
    logic [SIZE_W-1:0] row, logic [SIZE_W-1:0] col, logic [SIZE_W-1:0] cols
  );
    return row * cols + col;
  endfunction

  function automatic logic [PIX_W-1:0] blend_pair(
    logic [PIX_W-1:0] a, logic [PIX_W-1:0] b, logic [WEIGHT_W-1:0] w
  );
    logic [PIX_W-1:0] acc;
    logic [PIX_W-1:0] prod;
    acc  = a & PAIR_MASK;
    prod = ((b & PAIR_MASK) - acc) * w;
    acc  = acc + (prod >> WEIGHT_SHIFT);
    return acc & PAIR_MASK;
  endfunction

  function automatic logic [PIX_W-1:0] blend_argb(
    logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1, logic [WEIGHT_W-1:0] w
  );
    return blend_pair(p0, p1, w) | (blend_pair(p0 >> 8, p1 >> 8, w) << 8);
  endfunction

  function automatic logic [PIX_W-1:0] scale_pixel(
    logic [COORD_W-1:0] x, logic [COORD_W-1:0] y
  );
    logic [SIZE_W-1:0]   cols, x0, x1, y0, y1;
    logic [WEIGHT_W-1:0] wu, wv;
    logic [PIX_W-1:0]    top, bot;
    cols = (reg_width == '0) ? SIZE_W'(1) : reg_width;
    resolve_axis(x, reg_step_x, reg_width, x0, x1, wu);
    resolve_axis(y, reg_step_y, reg_height, y0, y1, wv);
    top = blend_argb(src_image_copy[pixel_addr(y0, x0, cols)],
                     src_image_copy[pixel_addr(y0, x1, cols)], wu);
    bot = blend_argb(src_image_copy[pixel_addr(y1, x0, cols)],
                     src_image_copy[pixel_addr(y1, x1, cols)], wu);
    return blend_argb(top, bot, wv);
  endfunction

  function automatic void apply_item(scaler_item_t it);
    if (it.cmd == CMD_LOAD) begin
      src_image_copy[it.addr] = it.pix;
    end else begin
      pixel_q.push_back(scale_pixel(it.x, it.y));
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic plan_load(logic [LOAD_ADR_W-1:0] addr, logic [PIX_W-1:0] pix);
    scaler_item_t it;
    it.cmd  = CMD_LOAD;
    it.addr = addr;
    it.pix  = pix;
    it.x    = COORD_W'($urandom);
    it.y    = COORD_W'($urandom);
    loaded_map[addr] = 1'b1;
    feed_q.push_back(it);
    item_cnt++;
  endtask

  // Loads any neighbor not yet written, then queues the sample
  task automatic plan_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    logic [SIZE_W-1:0]     cols, x0, x1, y0, y1;
    logic [WEIGHT_W-1:0]   wu, wv;
    logic [LOAD_ADR_W-1:0] nb [4];
    scaler_item_t          it;
    cols = (reg_width == '0) ? SIZE_W'(1) : reg_width;
    resolve_axis(x, reg_step_x, reg_width, x0, x1, wu);
    resolve_axis(y, reg_step_y, reg_height, y0, y1, wv);
    nb[0] = pixel_addr(y0, x0, cols);
    nb[1] = pixel_addr(y0, x1, cols);
    nb[2] = pixel_addr(y1, x0, cols);
    nb[3] = pixel_addr(y1, x1, cols);
    foreach (nb[i]) begin
      if (!loaded_map[nb[i]]) plan_load(nb[i], $urandom);
    end
    it.cmd  = CMD_SAMPLE;
    it.addr = LOAD_ADR_W'($urandom);
    it.pix  = $urandom;
    it.x    = x;
    it.y    = y;
    feed_q.push_back(it);
    item_cnt++;
  endtask

  // Mostly coordinates that land inside the image, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(
    logic [SIZE_W-1:0] size, logic [STEP_W-1:0] step
  );
    int unsigned lim;
    if ($urandom_range(99) < 25 || step == '0) return COORD_W'($urandom);
    lim = ((int'(size) + 1) << FRAC_W) / step + 1;
    if (lim > (1 << COORD_W) - 1) lim = (1 << COORD_W) - 1;
    return COORD_W'($urandom_range(lim));
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned start;
    start = item_cnt;
    while (item_cnt - start < n) begin
      if ($urandom_range(99) < 15) begin
        plan_load(LOAD_ADR_W'($urandom), $urandom);
      end else begin
        plan_sample(pick_coord(reg_width, reg_step_x), pick_coord(reg_height, reg_step_y));
      end
    end
  endtask

  // Loads leave no result, so allow the pipeline to empty after the last pixel
  task automatic wait_idle();
    while (feed_q.size() != 0 || tx_valid || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic program_regs(
    logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
    logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy
  );
    // upper bits of the size writes are junk on purpose
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SRC_WIDTH;
    cfg_wdata <= {(CFG_DATA_W-SIZE_W)'($urandom), w};
    @(negedge clk);
    cfg_addr  <= CFG_SRC_HEIGHT;
    cfg_wdata <= {(CFG_DATA_W-SIZE_W)'($urandom), h};
    @(negedge clk);
    cfg_addr  <= CFG_STEP_X;
    cfg_wdata <= sx;
    @(negedge clk);
    cfg_addr  <= CFG_STEP_Y;
    cfg_wdata <= sy;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_width  = w;
    reg_height = h;
    reg_step_x = sx;
    reg_step_y = sy;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 35;
    rx_idle_pct = 78;
    // Directed: 5x4 image, 0.75 and 0.5 steps
    program_regs(9'd5, 9'd4, 24'h00C000, 24'h008000);
    plan_load(16'hFFFF, 32'hFFFFFFFF);
    plan_load(16'h0000, 32'h00000000);
    plan_load(16'h0001, 32'hFFFFFFFF);
    plan_load(16'h0005, 32'h80FF0001);
    plan_load(16'h0006, 32'h7F00FFFE);
    plan_sample(12'd0, 12'd0);
    plan_sample(12'd1, 12'd1);
    plan_sample(12'd5, 12'd0);
    plan_sample(12'd6, 12'd7);
    plan_sample(12'hFFF, 12'hFFF);
    plan_load(16'h0001, 32'h00000000);
    plan_sample(12'd1, 12'd0);
    plan_sample(12'd1, 12'd2);
    wait_idle();

    program_regs(9'd256, 9'd256, 24'h010000, 24'h010000);
    run_random(85);
    wait_idle();
    // one column, zero rows (taken as one), extreme steps
    program_regs(9'd1, 9'd0, 24'hFFFFFF, 24'h000000);
    run_random(80);
    wait_idle();

    tx_idle_pct = 78;
    rx_idle_pct = 35;
    // sizes past 256 make addresses wrap
    program_regs(9'd511, 9'd511, 24'($urandom_range(24'h004000, 24'h030000)),
                 24'($urandom_range(24'h004000, 24'h030000)));
    run_random(85);
    wait_idle();
    program_regs(9'd0, 9'd256, 24'h000001, 24'h00FFFF);
    run_random(80);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(9'($urandom_range(2, 64)), 9'($urandom_range(2, 64)),
                 24'($urandom_range(24'h001000, 24'h040000)),
                 24'($urandom_range(24'h001000, 24'h040000)));
    run_random(45);
    rx_hold_go = ~rx_hold_go;
    // sender holds until every pixel is back
    wait_idle();
    run_random(45);
    wait_idle();
    program_regs(9'd256, 9'd511, 24'h7FFFFF, 24'($urandom));
    run_random(80);
    wait_idle();

    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst_n) begin
      tx_valid <= 1'b0;
    end else if (!tx_valid || in_fire) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_item  <= feed_q.pop_front();
        tx_valid <= 1'b1;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      rx_ready    <= 1'b0;
    end else if (rx_hold_go != rx_hold_seen) begin
      // long hold-off: pipeline fills and input ready must drop
      rx_hold_seen <= rx_hold_go;
      rx_hold_cnt  <= HOLD_CYCLES;
      rx_ready     <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    in_fire  = rst_n && tx_valid && in_if.ready;
    out_fire = rst_n && out_if.valid && rx_ready;
    if (in_fire) apply_item(tx_item);
    if (out_fire) begin
      if (pixel_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) $display("unexpected pixel transfer: %08h", out_if.pixel);
      end else begin
        want = pixel_q.pop_front();
        if (out_if.pixel !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("pixel mismatch: expected %08h, got %08h", want, out_if.pixel);
          end
        end
      end
    end
    if (in_fire || out_fire) dog_cnt = 0;
    else dog_cnt++;
    if (dog_cnt == DOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/core/bas_pkg.sv
rtl/core/bas_in_if.sv
rtl/core/bas_out_if.sv
rtl/core/bas_ram.sv
rtl/core/bilinear_argb_image_scaler.sv
bench/bilinear_argb_image_scaler_test.sv
